FILE: rtl/core/i2cm_pkg.sv
package i2cm_pkg;

  localparam int BufDepth = 16;
  localparam int BufAw = $clog2(BufDepth);
  localparam int LenW = 5;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_CMD  = 2'd1;
  localparam logic [1:0] OP_LOAD = 2'd2;

  localparam logic [2:0] K_PROBE = 3'd0;
  localparam logic [2:0] K_WREG  = 3'd1;
  localparam logic [2:0] K_RREG  = 3'd2;
  localparam logic [2:0] K_WBUF  = 3'd3;
  localparam logic [2:0] K_RBUF  = 3'd4;
  localparam logic [2:0] K_WCRC  = 3'd5;
  localparam logic [2:0] K_RCRC  = 3'd6;
  localparam logic [2:0] K_NONE  = 3'd7;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NACK = 2'd1;
  localparam logic [1:0] ST_BLEN = 2'd2;
  localparam logic [1:0] ST_CRC  = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] kind;
    logic [6:0] target_addr;
    logic [7:0] reg_addr;
    logic [7:0] data_byte;
    logic [4:0] length;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic [7:0] read_byte;
    logic       byte_valid;
    logic       last_byte;
    logic       done_res;
    logic [1:0] status;
  } res_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int j = 0; j < 8; j++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/i2cm_fifo.sv
module i2cm_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  i2cm_pkg::item_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output i2cm_pkg::item_t rd_data
);
  import i2cm_pkg::*;

  item_t mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign wr_ready = (cnt != 2'd2);
  assign rd_valid = (cnt != 2'd0);
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) begin
      mem[wp] <= wr_data;
    end
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp <= ~wp;
      if (rd_valid && rd_ready) rp <= ~rp;
      cnt <= cnt + 2'((wr_valid && wr_ready) ? 1 : 0) - 2'((rd_valid && rd_ready) ? 1 : 0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst) begin
      assert (cnt <= 2'd2) else $error("queue overflow");
    end
  end

  property p_no_pop_empty;
    @(posedge clk) disable iff (rst) (cnt == 2'd0) |-> !rd_valid;
  endproperty
  a_no_pop_empty: assert property (p_no_pop_empty) else $error("pop on empty queue");

  property p_full_blocks;
    @(posedge clk) disable iff (rst) (cnt == 2'd2) |-> !wr_ready;
  endproperty
  a_full_blocks: assert property (p_full_blocks) else $error("push on full queue");

  property p_count;
    @(posedge clk) disable iff (rst)
      (wr_valid && wr_ready && !(rd_valid && rd_ready)) |=> (cnt == $past(cnt) + 2'd1);
  endproperty
  a_count: assert property (p_count) else $error("queue count slip");

endmodule

FILE: rtl/core/i2cm_engine.sv
module i2cm_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  i2cm_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output i2cm_pkg::res_t  out_res
);
  import i2cm_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START1, PH_START2, PH_TXLO, PH_TXHI, PH_TXACK,
    PH_RXHI, PH_RXLO, PH_RXACK, PH_STOP1, PH_STOP2
  } phase_t;

  typedef enum logic [2:0] {
    SG_ADDRW, SG_REG, SG_DATA, SG_CRC, SG_BUF, SG_ADDRR, SG_RX
  } stage_t;

  phase_t     phase;
  stage_t     stage;
  logic [3:0] bit_count;
  logic [7:0] shift_reg;
  logic [4:0] byte_index;
  logic [7:0] crc_value;
  logic [2:0] h_kind;
  logic [6:0] h_dev;
  logic [7:0] h_reg;
  logic [7:0] h_data;
  logic [4:0] h_len;
  logic       scl, sda;
  logic [4:0] load_count;
  logic [1:0] final_status;
  logic [7:0] write_buffer [BufDepth];
  logic [7:0] buf_rd;

  logic       step;
  logic [4:0] bi_inc;
  logic       bad_len;
  logic       rx_last;
  logic [4:0] rx_total;
  logic       scl_next, sda_next;
  res_t       res_next;

  assign in_ready = !out_valid || out_ready;
  assign step = in_valid && in_ready;
  assign bi_inc = byte_index + 5'd1;
  assign bad_len = (in_item.length == '0) || (in_item.length > LenW'(BufDepth));
  assign rx_total = (h_kind == K_RBUF) ? h_len : ((h_kind == K_RCRC) ? 5'd2 : 5'd1);
  assign rx_last = (bi_inc >= rx_total);

  // The buffer byte for the next send is fetched while the current byte is on the bus.
  always_ff @(posedge clk) begin
    if (step && in_item.op == OP_LOAD && phase == PH_IDLE && load_count < 5'(BufDepth)) begin
      write_buffer[BufAw'(load_count)] <= in_item.data_byte;
    end
    buf_rd <= write_buffer[BufAw'(stage == SG_REG ? 5'd0 : bi_inc)];
  end

  always_comb begin
    scl_next = scl;
    sda_next = sda;
    res_next = '0;
    res_next.busy_res = (phase != PH_IDLE);
    unique case (in_item.op)
      OP_CMD: begin
        if (phase == PH_IDLE && in_item.kind != K_NONE) begin
          if ((in_item.kind == K_WBUF || in_item.kind == K_RBUF) && bad_len) begin
            res_next.done_res = 1'b1;
            res_next.status = ST_BLEN;
          end else begin
            res_next.busy_res = 1'b1;
          end
        end
      end
      OP_TICK: begin
        res_next.busy_res = 1'b1;
        unique case (phase)
          PH_IDLE: begin
            scl_next = 1'b1; sda_next = 1'b1;
            res_next.busy_res = 1'b0;
          end
          PH_START1: begin
            scl_next = 1'b1; sda_next = 1'b1;
          end
          PH_START2: begin
            scl_next = 1'b1; sda_next = 1'b0;
          end
          PH_TXLO: begin
            scl_next = 1'b0; sda_next = shift_reg[7];
          end
          PH_TXHI: begin
            scl_next = 1'b1; sda_next = shift_reg[7];
          end
          PH_TXACK: begin
            scl_next = 1'b1; sda_next = 1'b1;
          end
          PH_RXHI: begin
            scl_next = 1'b1; sda_next = 1'b1;
          end
          PH_RXLO: begin
            scl_next = 1'b0; sda_next = 1'b1;
          end
          PH_RXACK: begin
            scl_next = 1'b1; sda_next = rx_last;
            if (h_kind != K_RCRC) begin
              res_next.read_byte = shift_reg;
              res_next.byte_valid = 1'b1;
              res_next.last_byte = rx_last;
            end
          end
          PH_STOP1: begin
            scl_next = 1'b1; sda_next = 1'b0;
          end
          PH_STOP2: begin
            scl_next = 1'b1; sda_next = 1'b1;
            res_next.busy_res = 1'b0;
            res_next.done_res = 1'b1;
            res_next.status = final_status;
            if (h_kind == K_RCRC && final_status == ST_OK) begin
              res_next.read_byte = h_data;
              res_next.byte_valid = 1'b1;
              res_next.last_byte = 1'b1;
            end
          end
          default: begin
            scl_next = 1'b1; sda_next = 1'b1;
            res_next.busy_res = 1'b0;
          end
        endcase
      end
      default: ;
    endcase
    res_next.scl_out = scl_next;
    res_next.sda_out = sda_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      stage <= SG_ADDRW;
      bit_count <= '0;
      shift_reg <= '0;
      byte_index <= '0;
      crc_value <= '0;
      h_kind <= '0;
      h_dev <= '0;
      h_reg <= '0;
      h_data <= '0;
      h_len <= '0;
      scl <= 1'b1;
      sda <= 1'b1;
      load_count <= '0;
      final_status <= ST_OK;
      out_valid <= 1'b0;
      out_res <= '0;
    end else begin
      if (step) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (step) begin
        out_res <= res_next;
        scl <= scl_next;
        sda <= sda_next;
        unique case (in_item.op)
          OP_CMD: begin
            if (phase == PH_IDLE && in_item.kind != K_NONE &&
                !((in_item.kind == K_WBUF || in_item.kind == K_RBUF) && bad_len)) begin
              h_kind <= in_item.kind;
              h_dev <= in_item.target_addr;
              h_reg <= in_item.reg_addr;
              h_data <= in_item.data_byte;
              h_len <= in_item.length;
              crc_value <= (in_item.kind == K_WCRC) ?
                crc8_step(crc8_step(8'h00, in_item.reg_addr), in_item.data_byte) : 8'h00;
              load_count <= '0;
              final_status <= ST_OK;
              byte_index <= '0;
              stage <= SG_ADDRW;
              phase <= PH_START1;
            end
          end
          OP_LOAD: begin
            if (phase == PH_IDLE && load_count < 5'(BufDepth)) load_count <= load_count + 5'd1;
          end
          OP_TICK: begin
            unique case (phase)
              PH_IDLE: ;
              PH_START1: phase <= PH_START2;
              PH_START2: begin
                shift_reg <= {h_dev, stage == SG_ADDRR};
                bit_count <= '0;
                phase <= PH_TXLO;
              end
              PH_TXLO: phase <= PH_TXHI;
              PH_TXHI: begin
                shift_reg <= {shift_reg[6:0], 1'b0};
                bit_count <= bit_count + 4'd1;
                phase <= (bit_count >= 4'd7) ? PH_TXACK : PH_TXLO;
              end
              PH_TXACK: begin
                if (in_item.sda_in) begin
                  final_status <= ST_NACK;
                  phase <= PH_STOP1;
                end else begin
                  bit_count <= '0;
                  unique case (stage)
                    SG_ADDRW: begin
                      if (h_kind == K_PROBE) phase <= PH_STOP1;
                      else begin
                        stage <= SG_REG; shift_reg <= h_reg; phase <= PH_TXLO;
                      end
                    end
                    SG_REG: begin
                      if (h_kind == K_WREG || h_kind == K_WCRC) begin
                        stage <= SG_DATA; shift_reg <= h_data; phase <= PH_TXLO;
                      end else if (h_kind == K_WBUF) begin
                        stage <= SG_BUF; byte_index <= '0;
                        shift_reg <= buf_rd; phase <= PH_TXLO;
                      end else begin
                        stage <= SG_ADDRR; phase <= PH_START1;
                      end
                    end
                    SG_DATA: begin
                      if (h_kind == K_WCRC) begin
                        stage <= SG_CRC; shift_reg <= crc_value; phase <= PH_TXLO;
                      end else phase <= PH_STOP1;
                    end
                    SG_BUF: begin
                      byte_index <= bi_inc;
                      if (bi_inc >= h_len) phase <= PH_STOP1;
                      else begin
                        shift_reg <= (bi_inc < 5'(BufDepth)) ? buf_rd : 8'h00;
                        phase <= PH_TXLO;
                      end
                    end
                    SG_ADDRR: begin
                      stage <= SG_RX; byte_index <= '0;
                      shift_reg <= '0; phase <= PH_RXHI;
                    end
                    default: phase <= PH_STOP1;
                  endcase
                end
              end
              PH_RXHI: begin
                shift_reg <= {shift_reg[6:0], in_item.sda_in};
                bit_count <= bit_count + 4'd1;
                phase <= PH_RXLO;
              end
              PH_RXLO: phase <= (bit_count >= 4'd8) ? PH_RXACK : PH_RXHI;
              PH_RXACK: begin
                if (h_kind == K_RCRC) begin
                  if (byte_index == '0) h_data <= shift_reg;
                  else if (crc8_step(8'h00, h_data) != shift_reg) final_status <= ST_CRC;
                end
                byte_index <= bi_inc;
                if (rx_last) phase <= PH_STOP1;
                else begin
                  bit_count <= '0; shift_reg <= '0; phase <= PH_RXHI;
                end
              end
              PH_STOP1: phase <= PH_STOP2;
              PH_STOP2: phase <= PH_IDLE;
              default: phase <= PH_IDLE;
            endcase
          end
          default: ;
        endcase
      end
    end
  end

  property p_done_idle;
    @(posedge clk) disable iff (rst) (out_valid && out_res.done_res) |-> !out_res.busy_res;
  endproperty
  a_done_idle: assert property (p_done_idle) else $error("done while busy");

  property p_ok_status;
    @(posedge clk) disable iff (rst) (out_valid && !out_res.done_res) |-> (out_res.status == ST_OK);
  endproperty
  a_ok_status: assert property (p_ok_status) else $error("status without done");

  property p_hold;
    @(posedge clk) disable iff (rst) (out_valid && !out_ready) |=> ($stable(out_res) && out_valid);
  endproperty
  a_hold: assert property (p_hold) else $error("result changed while stalled");

endmodule

FILE: rtl/core/i2c_master_register_access_crc8_core.sv
// I2C master for register, buffer and CRC8 (polynomial 0x07) protected register access. Each
// input transaction is a bus tick, a command start or a buffer load, and produces exactly one
// result transaction with the line drives and any status. One item per clock is sustained
// while m_tready is high: a two-entry queue decouples the input from the bus sequencer,
// which processes one item per cycle into a registered result stage unless it is stalled.
module i2c_master_register_access_crc8_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // op[1:0], kind[4:2], target_addr[11:5], reg_addr[19:12], data_byte[27:20], length[32:28],
  // sda_in[33], zero fill above
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // scl_out[0], sda_out[1], busy_res[2], read_byte[10:3], byte_valid[11], last_byte[12],
  // done_res[13], status[15:14]
  output logic [15:0] m_tdata
);
  import i2cm_pkg::*;

  item_t in_item, q_item;
  res_t  res;
  logic  q_valid, q_ready;

  assign in_item.op          = s_tdata[1:0];
  assign in_item.kind        = s_tdata[4:2];
  assign in_item.target_addr = s_tdata[11:5];
  assign in_item.reg_addr    = s_tdata[19:12];
  assign in_item.data_byte   = s_tdata[27:20];
  assign in_item.length      = s_tdata[32:28];
  assign in_item.sda_in      = s_tdata[33];

  i2cm_fifo u_fifo (
    .clk(clk), .rst(rst),
    .wr_valid(s_tvalid), .wr_ready(s_tready), .wr_data(in_item),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_item)
  );

  i2cm_engine u_engine (
    .clk(clk), .rst(rst),
    .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
  );

  assign m_tdata = {res.status, res.done_res, res.last_byte, res.byte_valid, res.read_byte,
                    res.busy_res, res.sda_out, res.scl_out};

endmodule
